FILE: rtl/pi_position_controller_macros.svh
// ---------------------------------------------------------------------------
// PI position controller assertion macros
// Shared concurrent assertion forms for the controller RTL.
// ---------------------------------------------------------------------------
`ifndef PI_POSITION_CONTROLLER_MACROS_SVH
`define PI_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PIPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PIPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pipc_pkg.sv
// ---------------------------------------------------------------------------
// pipc_pkg
// Types and constants shared by the PI position controller modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pipc_pkg;

	// Fixed-point layout
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned PERIOD_W  = 17;
	localparam int unsigned ERR_W     = DATA_W + 1;
	localparam int unsigned PROD_W    = 2 * ERR_W;
	localparam int unsigned SUM_W     = 51;
	localparam int unsigned IDX_W     = 3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_TICK_PERIOD = 3'd2;
	localparam logic [IDX_W-1:0] REG_INTEG_LOW   = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTEG_HIGH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_LOW   = 3'd5;
	localparam logic [IDX_W-1:0] REG_DRIVE_HIGH  = 3'd6;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd65;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_T,
		S_ACC_I,
		S_CLP_I,
		S_MUL_P,
		S_MUL_K,
		S_ADD_U,
		S_CLP_U
	} state_t;

	// Multiplier operand selection
	typedef enum logic [1:0] {
		MSEL_PERIOD,
		MSEL_PROP,
		MSEL_INTEG
	} mul_sel_t;

	// Adder operand selection
	typedef enum logic [1:0] {
		ASEL_INTEG,
		ASEL_PTERM,
		ASEL_DRIVE
	} add_sel_t;

	// Clamp bound selection
	typedef enum logic {
		CSEL_INTEG,
		CSEL_DRIVE
	} clamp_sel_t;

	// Datapath control from the sequencer
	typedef struct packed {
		logic       err_en;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic       add_en;
		add_sel_t   add_sel;
		clamp_sel_t clamp_sel;
		logic       integ_en;
		logic       drive_en;
	} ctrl_t;

	// Configuration register contents
	typedef struct packed {
		logic signed [DATA_W-1:0] prop_gain;
		logic signed [DATA_W-1:0] integ_gain;
		logic [PERIOD_W-1:0]      tick_period;
		logic signed [DATA_W-1:0] integ_low;
		logic signed [DATA_W-1:0] integ_high;
		logic signed [DATA_W-1:0] drive_low;
		logic signed [DATA_W-1:0] drive_high;
	} cfg_t;

endpackage

FILE: rtl/pipc_cfg_regs.sv
// ---------------------------------------------------------------------------
// pipc_cfg_regs
// Configuration register file: gains, tick period and clamp bounds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipc_cfg_regs
	import pipc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= '0;
			cfg_q.integ_gain  <= '0;
			cfg_q.tick_period <= PERIOD_RESET;
			cfg_q.integ_low   <= '0;
			cfg_q.integ_high  <= '0;
			cfg_q.drive_low   <= '0;
			cfg_q.drive_high  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:   cfg_q.prop_gain   <= signed'(cfg_data);
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= signed'(cfg_data);
				REG_TICK_PERIOD: cfg_q.tick_period <= cfg_data[PERIOD_W-1:0];
				REG_INTEG_LOW:   cfg_q.integ_low   <= signed'(cfg_data);
				REG_INTEG_HIGH:  cfg_q.integ_high  <= signed'(cfg_data);
				REG_DRIVE_LOW:   cfg_q.drive_low   <= signed'(cfg_data);
				REG_DRIVE_HIGH:  cfg_q.drive_high  <= signed'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/pipc_datapath.sv
// ---------------------------------------------------------------------------
// pipc_datapath
// Shared multiplier, adder and clamp unit with the controller's registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipc_datapath
	import pipc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	input  cfg_t                     cfg,
	input  logic signed [DATA_W-1:0] target_pos,
	input  logic signed [DATA_W-1:0] measured_pos,
	output logic signed [DATA_W-1:0] drive
);

	logic signed [ERR_W-1:0]  err_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [DATA_W-1:0] integral_q;
	logic signed [DATA_W-1:0] drive_q;

	logic signed [ERR_W-1:0]  err_d;
	logic signed [ERR_W-1:0]  mul_a;
	logic signed [ERR_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [SUM_W-1:0]  add_a;
	logic signed [SUM_W-1:0]  add_b;
	logic signed [SUM_W-1:0]  sum_d;
	logic signed [SUM_W-1:0]  lo_x;
	logic signed [SUM_W-1:0]  hi_x;
	logic signed [SUM_W-1:0]  clip_hi;
	logic signed [SUM_W-1:0]  clip_lo;

	// Position error at full precision
	assign err_d = ERR_W'(target_pos) - ERR_W'(measured_pos);

	// Pick multiplier operands
	always_comb begin
		case (ctrl.mul_sel)
			MSEL_PERIOD: begin
				mul_a = err_q;
				mul_b = signed'({{(ERR_W - PERIOD_W){1'b0}}, cfg.tick_period});
			end
			MSEL_PROP: begin
				mul_a = err_q;
				mul_b = ERR_W'(cfg.prop_gain);
			end
			MSEL_INTEG: begin
				mul_a = ERR_W'(integral_q);
				mul_b = ERR_W'(cfg.integ_gain);
			end
			default: begin
				mul_a = err_q;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Drop the fraction of the last product, rounding toward minus infinity
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign add_b   = signed'(prod_sh[SUM_W-1:0]);

	// Pick adder operand
	always_comb begin
		case (ctrl.add_sel)
			ASEL_INTEG: add_a = SUM_W'(integral_q);
			ASEL_PTERM: add_a = '0;
			ASEL_DRIVE: add_a = sum_q;
			default:    add_a = '0;
		endcase
	end

	assign sum_d = add_a + add_b;

	// Clamp the sum: upper bound first, then lower bound
	always_comb begin
		if (ctrl.clamp_sel == CSEL_INTEG) begin
			lo_x = SUM_W'(cfg.integ_low);
			hi_x = SUM_W'(cfg.integ_high);
		end else begin
			lo_x = SUM_W'(cfg.drive_low);
			hi_x = SUM_W'(cfg.drive_high);
		end
		clip_hi = (sum_q > hi_x) ? hi_x : sum_q;
		clip_lo = (clip_hi < lo_x) ? lo_x : clip_hi;
	end

	// Hold the working registers
	always_ff @(posedge clk) begin
		if (ctrl.err_en) begin
			err_q <= err_d;
		end
		if (ctrl.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctrl.add_en) begin
			sum_q <= sum_d;
		end
		if (ctrl.drive_en) begin
			drive_q <= signed'(clip_lo[DATA_W-1:0]);
		end
	end

	// Integral state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (ctrl.integ_en) begin
			integral_q <= signed'(clip_lo[DATA_W-1:0]);
		end
	end

	assign drive = drive_q;

endmodule

FILE: rtl/pipc_seq.sv
// ---------------------------------------------------------------------------
// pipc_seq
// Sequencer that steps the shared datapath through one control tick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pi_position_controller_macros.svh"

module pipc_seq
	import pipc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_blocked;

	// Result register still holds an untaken transaction
	assign out_blocked = out_valid_q && out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_MUL_T;
			S_MUL_T: state_d = S_ACC_I;
			S_ACC_I: state_d = S_CLP_I;
			S_CLP_I: state_d = S_MUL_P;
			S_MUL_P: state_d = S_MUL_K;
			S_MUL_K: state_d = S_ADD_U;
			S_ADD_U: state_d = S_CLP_U;
			S_CLP_U: if (!out_blocked) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath control
	always_comb begin
		ctrl = '{
			err_en:    1'b0,
			mul_en:    1'b0,
			mul_sel:   MSEL_PERIOD,
			add_en:    1'b0,
			add_sel:   ASEL_INTEG,
			clamp_sel: CSEL_INTEG,
			integ_en:  1'b0,
			drive_en:  1'b0
		};
		case (state_q)
			S_IDLE: begin
				ctrl.err_en = in_valid;
			end
			S_MUL_T: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MSEL_PERIOD;
			end
			S_ACC_I: begin
				ctrl.add_en  = 1'b1;
				ctrl.add_sel = ASEL_INTEG;
			end
			S_CLP_I: begin
				ctrl.clamp_sel = CSEL_INTEG;
				ctrl.integ_en  = 1'b1;
			end
			S_MUL_P: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MSEL_PROP;
			end
			S_MUL_K: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MSEL_INTEG;
				ctrl.add_en  = 1'b1;
				ctrl.add_sel = ASEL_PTERM;
			end
			S_ADD_U: begin
				ctrl.add_en  = 1'b1;
				ctrl.add_sel = ASEL_DRIVE;
			end
			S_CLP_U: begin
				ctrl.clamp_sel = CSEL_DRIVE;
				ctrl.drive_en  = !out_blocked;
			end
			default: begin
			end
		endcase
	end

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.drive_en) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`PIPC_ASSERT_NXT(a_accept_starts, clk, arst_n, in_valid && !in_stall, state_q == S_MUL_T, "accepted transaction did not start the multiply")
	`PIPC_ASSERT_NXT(a_drive_posts, clk, arst_n, ctrl.drive_en, out_valid, "drive update did not raise result valid")
	`PIPC_ASSERT_IMP(a_no_overwrite, clk, arst_n, out_valid && out_stall, !ctrl.drive_en, "drive overwritten while result stalled")
	`PIPC_ASSERT_IMP(a_one_write, clk, arst_n, 1'b1, $onehot0({ctrl.err_en, ctrl.integ_en, ctrl.drive_en}), "more than one state write in a cycle")

endmodule

FILE: rtl/pi_position_controller.sv
// ---------------------------------------------------------------------------
// pi_position_controller
// PI position controller with integrator clamp, signed Q16.16 throughout.
// ---------------------------------------------------------------------------
//
//  channel  signals                              direction
//  input    in_valid/in_stall, target_pos,       in  (stall out)
//           measured_pos
//  output   out_valid/out_stall, drive           out (stall in)
//  config   cfg_we, cfg_index, cfg_data          in, write only
//
//  The accept cycle loads the error, then seven sequencer steps share one 33x33
//  multiplier, one 51-bit adder and one clamp.
//  in_stall is high from the cycle after acceptance until the sequencer is idle.
//  A stalled result holds the final clamp step; a new transaction is taken while
//  an earlier result waits. Reset clears the integral and the config registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pi_position_controller
	import pipc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] target_pos,
	input  logic signed [DATA_W-1:0] measured_pos,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] drive,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	cfg_t  cfg;
	ctrl_t ctrl;

	// Configuration registers
	pipc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Tick sequencer
	pipc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	// Shared arithmetic
	pipc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cfg          (cfg),
		.target_pos   (target_pos),
		.measured_pos (measured_pos),
		.drive        (drive)
	);

endmodule

FILE: test/pi_position_controller_tb.sv
// ---------------------------------------------------------------------------
// pi_position_controller_tb
// Self-checking bench for the PI position controller. A queue of control ticks
// feeds a clocked driver, and every accepted tick is run through a local
// fixed-point controller to predict its drive. A clocked monitor compares each
// drive result against the oldest prediction. Gains, period and clamps are
// reprogrammed between phases, including inverted clamps, zero and long
// periods, and extreme values. Random idling is applied on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pi_position_controller_tb;
	import pipc_pkg::*;

	localparam int TIMEOUT_CYCLES = 200000;
	localparam int TAIL_CYCLES    = 16;
	localparam int RANDOM_PHASES  = 6;
	localparam int TICKS_PER_PHASE = 72;

	localparam logic [IDX_W-1:0]         REG_UNUSED = 3'd7;
	localparam logic signed [DATA_W-1:0] POS_MIN    = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] POS_MAX    = 32'sh7FFF_FFFF;

	typedef struct {
		logic signed [DATA_W-1:0] target;
		logic signed [DATA_W-1:0] measured;
		bit                       drain_first;
	} tick_t;

	// Block ports
	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     in_valid     = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] target_pos   = '0;
	logic signed [DATA_W-1:0] measured_pos = '0;
	logic                     out_valid;
	logic                     out_stall    = 1'b0;
	logic signed [DATA_W-1:0] drive;
	logic                     cfg_we       = 1'b0;
	logic [IDX_W-1:0]         cfg_index    = '0;
	logic [DATA_W-1:0]        cfg_data     = '0;

	// Local controller state
	cfg_t                     ctl_cfg;
	logic signed [DATA_W-1:0] ctl_integral;

	tick_t                    tick_queue[$];
	logic signed [DATA_W-1:0] pending_drives[$];

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int cycle_count     = 0;
	int mismatch_count  = 0;
	int ticks_issued    = 0;
	int results_seen    = 0;
	int reg_writes      = 0;
	int integ_clamped   = 0;
	int drive_clamped   = 0;

	pi_position_controller DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_pos   (target_pos),
		.measured_pos (measured_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive        (drive),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Clamp with the upper bound applied first, so an inverted pair yields low
	function automatic longint clamp_to(input longint x, input logic signed [DATA_W-1:0] lo,
			input logic signed [DATA_W-1:0] hi);
		if (x > longint'(hi))
			x = longint'(hi);
		if (x < longint'(lo))
			x = longint'(lo);
		return x;
	endfunction

	// Advance the local integrator by one tick and return the clamped drive
	function automatic logic signed [DATA_W-1:0] predict_drive(
			input logic signed [DATA_W-1:0] tgt, input logic signed [DATA_W-1:0] meas);
		longint err;
		longint acc;
		longint pterm;
		longint iterm;
		longint u_raw;
		longint u;
		err = longint'(tgt) - longint'(meas);
		acc = longint'(ctl_integral)
			+ ((err * longint'(ctl_cfg.tick_period)) >>> FRAC_BITS);
		ctl_integral = DATA_W'(clamp_to(acc, ctl_cfg.integ_low, ctl_cfg.integ_high));
		if (longint'(ctl_integral) != acc)
			integ_clamped++;
		pterm = (longint'($signed(ctl_cfg.prop_gain)) * err) >>> FRAC_BITS;
		iterm = (longint'($signed(ctl_cfg.integ_gain)) * longint'(ctl_integral)) >>> FRAC_BITS;
		u_raw = pterm + iterm;
		u = clamp_to(u_raw, ctl_cfg.drive_low, ctl_cfg.drive_high);
		if (u != u_raw)
			drive_clamped++;
		return u[DATA_W-1:0];
	endfunction

	// Mirror a register write; unknown indexes are dropped
	function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		case (idx)
			REG_PROP_GAIN:   ctl_cfg.prop_gain   = data;
			REG_INTEG_GAIN:  ctl_cfg.integ_gain  = data;
			REG_TICK_PERIOD: ctl_cfg.tick_period = data[PERIOD_W-1:0];
			REG_INTEG_LOW:   ctl_cfg.integ_low   = data;
			REG_INTEG_HIGH:  ctl_cfg.integ_high  = data;
			REG_DRIVE_LOW:   ctl_cfg.drive_low   = data;
			REG_DRIVE_HIGH:  ctl_cfg.drive_high  = data;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		mismatch_count++;
		$display("[%0t] MISMATCH %s: drive got %h expected %h", $realtime, what, got, want);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		apply_reg(idx, data);
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Load a full register set, with junk in the unused period bits
	task automatic program_controller(input cfg_t c);
		logic [DATA_W-1:0] junk;
		junk = $urandom();
		write_reg(REG_PROP_GAIN, c.prop_gain);
		write_reg(REG_INTEG_GAIN, c.integ_gain);
		write_reg(REG_TICK_PERIOD, {junk[DATA_W-1:PERIOD_W], c.tick_period});
		write_reg(REG_INTEG_LOW, c.integ_low);
		write_reg(REG_INTEG_HIGH, c.integ_high);
		write_reg(REG_DRIVE_LOW, c.drive_low);
		write_reg(REG_DRIVE_HIGH, c.drive_high);
		write_reg(REG_UNUSED, $urandom());
	endtask

	// Hold until every issued tick has produced its drive
	task automatic settle();
		while (results_seen != ticks_issued)
			@(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct  = 37;
				recv_stall_pct = 64;
			end
			1: begin
				send_idle_pct  = 64;
				recv_stall_pct = 37;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	function automatic void queue_tick(input logic signed [DATA_W-1:0] tgt,
			input logic signed [DATA_W-1:0] meas, input bit drain);
		tick_t tk;
		tk.target      = tgt;
		tk.measured    = meas;
		tk.drain_first = drain;
		tick_queue.push_back(tk);
		ticks_issued++;
	endfunction

	function automatic cfg_t make_cfg(input logic signed [DATA_W-1:0] pg,
			input logic signed [DATA_W-1:0] ig, input logic [PERIOD_W-1:0] per,
			input logic signed [DATA_W-1:0] il, input logic signed [DATA_W-1:0] ih,
			input logic signed [DATA_W-1:0] dl, input logic signed [DATA_W-1:0] dh);
		cfg_t c;
		c.prop_gain   = pg;
		c.integ_gain  = ig;
		c.tick_period = per;
		c.integ_low   = il;
		c.integ_high  = ih;
		c.drive_low   = dl;
		c.drive_high  = dh;
		return c;
	endfunction

	function automatic logic signed [DATA_W-1:0] extreme_value();
		case ($urandom_range(0, 3))
			0: return POS_MIN;
			1: return POS_MAX;
			2: return '0;
			default: return -1;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return POS_MIN;
			1: return POS_MAX;
			2, 3: return int'($urandom_range(0, 524288)) - 262144;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [PERIOD_W-1:0] rand_period();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 17'h10000;
			2: return 17'h1FFFF;
			3, 4: return PERIOD_W'($urandom_range(1, 6554));
			default: return PERIOD_W'($urandom_range(0, 131071));
		endcase
	endfunction

	// Wide, ordered, inverted, narrow or single-point clamp pair
	function automatic void rand_bounds(output logic signed [DATA_W-1:0] lo,
			output logic signed [DATA_W-1:0] hi);
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		a = $urandom();
		b = $urandom();
		case ($urandom_range(0, 5))
			0, 1: begin
				lo = POS_MIN;
				hi = POS_MAX;
			end
			2: begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
			3: begin
				lo = (a < b) ? b : a;
				hi = (a < b) ? a : b;
			end
			4: begin
				hi = $urandom_range(0, 4194304);
				lo = -hi;
			end
			default: begin
				lo = a;
				hi = a;
			end
		endcase
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		c.prop_gain   = rand_gain();
		c.integ_gain  = rand_gain();
		c.tick_period = rand_period();
		rand_bounds(lo, hi);
		c.integ_low  = lo;
		c.integ_high = hi;
		rand_bounds(lo, hi);
		c.drive_low  = lo;
		c.drive_high = hi;
		return c;
	endfunction

	// Mostly tracking ticks near the target, plus wide, extreme and zero-error ones
	function automatic void queue_random_tick(input bit drain);
		logic signed [DATA_W-1:0] t;
		logic signed [DATA_W-1:0] m;
		case ($urandom_range(0, 9))
			6, 7: begin
				t = $urandom();
				m = $urandom();
			end
			8: begin
				t = extreme_value();
				m = extreme_value();
			end
			9: begin
				t = $urandom();
				m = t;
			end
			default: begin
				t = int'($urandom_range(0, 33554432)) - 16777216;
				m = t + (int'($urandom_range(0, 262144)) - 131072);
			end
		endcase
		queue_tick(t, m, drain);
	endfunction

	// Driver: hold a stalled transaction, otherwise present the next tick or idle
	always @(posedge clk) begin : tick_driver
		tick_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_drives.push_back(predict_drive(target_pos, measured_pos));
			if (!in_valid || !in_stall) begin
				if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
						&& (!tick_queue[0].drain_first || pending_drives.size() == 0)) begin
					nxt = tick_queue.pop_front();
					in_valid     <= 1'b1;
					target_pos   <= nxt.target;
					measured_pos <= nxt.measured;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Monitor: check each drive transaction against the oldest prediction
	always @(posedge clk) begin : drive_monitor
		logic signed [DATA_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_drives.size() == 0) begin
				report_mismatch("result with no tick outstanding", drive, 'x);
			end else begin
				want = pending_drives.pop_front();
				if (drive !== want)
					report_mismatch("wrong drive", drive, want);
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= TIMEOUT_CYCLES);
		$display("Timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int p;
		int i;
		ctl_cfg = make_cfg('0, '0, PERIOD_RESET, '0, '0, '0, '0);
		ctl_integral = '0;
		set_idling(0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: all clamps at zero
		queue_tick(POS_MAX, POS_MIN, 1'b0);
		queue_tick(POS_MIN, POS_MAX, 1'b0);
		settle();

		// Unity proportional gain, half integral gain, unit period, full range, including floor rounding
		program_controller(make_cfg(32'sh0001_0000, 32'sh0000_8000, 17'h10000,
			POS_MIN, POS_MAX, POS_MIN, POS_MAX));
		queue_tick('0, '0, 1'b0);
		queue_tick(POS_MAX, POS_MIN, 1'b0);
		queue_tick(POS_MIN, POS_MAX, 1'b0);
		queue_tick(32'sh0001_0000, '0, 1'b0);
		queue_tick(-1, '0, 1'b0);
		queue_tick(5, -3, 1'b0);
		settle();

		// Extreme gains with the longest period
		program_controller(make_cfg(POS_MIN, POS_MAX, 17'h1FFFF,
			POS_MIN, POS_MAX, POS_MIN, POS_MAX));
		queue_tick(POS_MAX, POS_MIN, 1'b0);
		queue_tick(POS_MIN, POS_MAX, 1'b0);
		queue_tick(1, '0, 1'b0);
		queue_tick('0, 1, 1'b0);
		settle();

		// Inverted clamps on both the integral and the drive
		program_controller(make_cfg(32'sh0002_0000, 32'sh0001_0000, 17'h10000,
			32'sh0010_0000, -32'sh0010_0000, 1000, -1000));
		queue_tick(32'sh0005_0000, '0, 1'b0);
		queue_tick('0, 32'sh0005_0000, 1'b0);
		queue_tick('0, '0, 1'b0);
		settle();

		// Zero period freezes the integral; narrow clamps
		program_controller(make_cfg(32'sh0000_4000, -32'sh0003_0000, '0,
			-65536, 65536, -131072, 131072));
		queue_tick(32'sh0100_0000, '0, 1'b0);
		queue_tick(-1, 1, 1'b0);
		queue_tick(POS_MIN, POS_MIN, 1'b0);
		settle();

		// Random phases, each with its own register set and one full drain
		for (p = 0; p < RANDOM_PHASES; p++) begin
			set_idling(p / 2);
			program_controller(rand_cfg());
			for (i = 0; i < TICKS_PER_PHASE; i++)
				queue_random_tick(i == TICKS_PER_PHASE / 2);
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_drives.size() != 0)
			report_mismatch("prediction left without a result", 'x, pending_drives[0]);

		$display("Checked %0d drive results over %0d ticks and %0d register writes",
			results_seen, ticks_issued, reg_writes);
		$display("Integral clamp engaged %0d times, drive clamp %0d times, %0d mismatches",
			integ_clamped, drive_clamped, mismatch_count);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
